@@ rtl/bmp24_pkg.sv @@
// Shared types and constants for the 24-bit BMP stream decoder.
// No dependencies; the front end, back end and top level in rtl/ import this package.
package bmp24_pkg;

    // Header layout of a BMP file, in bytes.
    localparam int unsigned HDR_LEN      = 54;
    localparam int unsigned OFS_DATA_OFS = 10;
    localparam int unsigned OFS_WIDTH    = 18;
    localparam int unsigned OFS_HEIGHT   = 22;
    localparam int unsigned OFS_BPP      = 28;
    localparam int unsigned BPP_SUPPORTED = 24;

    // Result status codes.
    localparam logic [1:0] ST_PIXEL      = 2'd0;
    localparam logic [1:0] ST_BAD_BPP    = 2'd1;
    localparam logic [1:0] ST_TOO_LARGE  = 2'd2;
    localparam logic [1:0] ST_BAD_OFFSET = 2'd3;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_SKIP,
        PH_PIXEL,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        CMD_START,
        CMD_DATA,
        CMD_ERROR
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] data;
        logic [1:0] status;
    } t_cmd;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       first_of_file;
    } t_in;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] column;
        logic [11:0] row;
        logic [1:0]  status;
        logic        last;
    } t_out;

endpackage

@@ rtl/bmp24_front.sv @@
// Front end: tracks the byte position, collects and checks the header,
// skips to the pixel data and issues commands to the back end. Uses bmp24_pkg.
module bmp24_front #(
    parameter int unsigned MAX_DIM = 4096,
    parameter int unsigned DIM_W   = 13
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  bmp24_pkg::t_in    i_in,
    output logic              o_push,
    output bmp24_pkg::t_cmd   o_cmd,
    output logic [DIM_W-1:0]  o_cmd_w,
    output logic [DIM_W-1:0]  o_cmd_h
);
    import bmp24_pkg::*;

    t_phase      r_phase, n_phase;
    logic [31:0] r_pos, n_pos;
    logic [31:0] r_ofs, n_ofs;
    logic [31:0] r_width, n_width;
    logic [31:0] r_height, n_height;
    logic [15:0] r_bpp, n_bpp;

    t_phase      phase_eff;
    logic [31:0] pos;
    logic [7:0]  b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_pos    <= '0;
            r_ofs    <= '0;
            r_width  <= '0;
            r_height <= '0;
            r_bpp    <= '0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_ofs    <= n_ofs;
            r_width  <= n_width;
            r_height <= n_height;
            r_bpp    <= n_bpp;
        end
    end

    always_comb begin
        b         = i_in.file_byte;
        // A first byte restarts the parse before the byte itself is taken.
        phase_eff = i_in.first_of_file ? PH_HEADER : r_phase;
        pos       = i_in.first_of_file ? 32'd0 : r_pos;
        n_ofs     = i_in.first_of_file ? 32'd0 : r_ofs;
        n_width   = i_in.first_of_file ? 32'd0 : r_width;
        n_height  = i_in.first_of_file ? 32'd0 : r_height;
        n_bpp     = i_in.first_of_file ? 16'd0 : r_bpp;
        n_pos     = (pos == 32'hFFFF_FFFF) ? pos : pos + 32'd1;
        n_phase   = phase_eff;
        o_push    = 1'b0;
        o_cmd     = '{kind: CMD_DATA, data: b, status: ST_PIXEL};
        o_cmd_w   = DIM_W'(n_width);
        o_cmd_h   = DIM_W'(n_height);

        case (phase_eff)
            PH_HEADER: begin
                if (pos < 32'd64) begin
                    case (pos[5:0])
                        6'(OFS_DATA_OFS):     n_ofs[7:0]     = b;
                        6'(OFS_DATA_OFS + 1): n_ofs[15:8]    = b;
                        6'(OFS_DATA_OFS + 2): n_ofs[23:16]   = b;
                        6'(OFS_DATA_OFS + 3): n_ofs[31:24]   = b;
                        6'(OFS_WIDTH):        n_width[7:0]   = b;
                        6'(OFS_WIDTH + 1):    n_width[15:8]  = b;
                        6'(OFS_WIDTH + 2):    n_width[23:16] = b;
                        6'(OFS_WIDTH + 3):    n_width[31:24] = b;
                        6'(OFS_HEIGHT):       n_height[7:0]  = b;
                        6'(OFS_HEIGHT + 1):   n_height[15:8] = b;
                        6'(OFS_HEIGHT + 2):   n_height[23:16] = b;
                        6'(OFS_HEIGHT + 3):   n_height[31:24] = b;
                        6'(OFS_BPP):          n_bpp[7:0]     = b;
                        6'(OFS_BPP + 1):      n_bpp[15:8]    = b;
                        default: ;
                    endcase
                end
                if (pos == 32'(HDR_LEN - 1)) begin
                    // The checks are ordered; only the first failing one is reported.
                    if (n_bpp != 16'(BPP_SUPPORTED)) begin
                        o_push     = 1'b1;
                        o_cmd.kind = CMD_ERROR;
                        o_cmd.status = ST_BAD_BPP;
                        n_phase    = PH_DONE;
                    end else if (n_width > 32'(MAX_DIM) || n_height > 32'(MAX_DIM)) begin
                        o_push     = 1'b1;
                        o_cmd.kind = CMD_ERROR;
                        o_cmd.status = ST_TOO_LARGE;
                        n_phase    = PH_DONE;
                    end else if (n_ofs < 32'(HDR_LEN)) begin
                        o_push     = 1'b1;
                        o_cmd.kind = CMD_ERROR;
                        o_cmd.status = ST_BAD_OFFSET;
                        n_phase    = PH_DONE;
                    end else if (n_width == 32'd0 || n_height == 32'd0) begin
                        n_phase = PH_DONE;
                    end else begin
                        o_push     = 1'b1;
                        o_cmd.kind = CMD_START;
                        n_phase    = (n_ofs == 32'(HDR_LEN)) ? PH_PIXEL : PH_SKIP;
                    end
                end
            end
            PH_SKIP: begin
                if (pos == r_ofs) begin
                    o_push  = 1'b1;
                    n_phase = PH_PIXEL;
                end
            end
            PH_PIXEL: begin
                // The back end drops bytes once the image is complete.
                o_push = 1'b1;
            end
            PH_DONE: ;
            default: n_phase = PH_DONE;
        endcase
    end

endmodule

@@ rtl/bmp24_queue.sv @@
// Small flip-flop FIFO that decouples the front end from the back end.
// Generic payload; no package dependencies.
module bmp24_queue #(
    parameter int unsigned DEPTH = 4,
    parameter int unsigned WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        do_push  = i_push && !o_full;
        do_pop   = i_pop && o_valid;
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ rtl/bmp24_back.sv @@
// Back end: assembles BGR triples into RGB pixels, tracks column, row and
// line padding, and holds the result register. Uses bmp24_pkg.
module bmp24_back #(
    parameter int unsigned DIM_W = 13
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  bmp24_pkg::t_cmd   i_cmd,
    input  logic [DIM_W-1:0]  i_cmd_w,
    input  logic [DIM_W-1:0]  i_cmd_h,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output bmp24_pkg::t_out   o_out
);
    import bmp24_pkg::*;

    logic             r_active, n_active;
    logic             r_in_pad, n_in_pad;
    logic [1:0]       r_k, n_k;
    logic [1:0]       r_pad, n_pad;
    logic [DIM_W-1:0] r_w, n_w;
    logic [DIM_W-1:0] r_col, n_col;
    logic [DIM_W-1:0] r_row, n_row;
    logic [7:0]       r_blue, n_blue;
    logic [7:0]       r_green, n_green;
    logic             r_out_valid, n_out_valid;
    t_out             r_out, n_out;
    logic [1:0]       pad_len;
    logic             last_col;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        // Each line of 3*width bytes is padded by width mod 4 bytes.
        pad_len     = 2'(r_w);
        last_col    = (r_col == DIM_W'(r_w - 1'b1));
        o_pop       = i_cmd_valid && (!r_out_valid || i_out_ready);
        n_active    = r_active;
        n_in_pad    = r_in_pad;
        n_k         = r_k;
        n_pad       = r_pad;
        n_w         = r_w;
        n_col       = r_col;
        n_row       = r_row;
        n_blue      = r_blue;
        n_green     = r_green;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        if (o_pop) begin
            case (i_cmd.kind)
                CMD_START: begin
                    n_active = 1'b1;
                    n_in_pad = 1'b0;
                    n_k      = 2'd0;
                    n_pad    = 2'd0;
                    n_w      = i_cmd_w;
                    n_col    = '0;
                    n_row    = DIM_W'(i_cmd_h - 1'b1);
                end
                CMD_ERROR: begin
                    n_active    = 1'b0;
                    n_out       = '0;
                    n_out.status = i_cmd.status;
                    n_out.last  = 1'b1;
                    n_out_valid = 1'b1;
                end
                CMD_DATA: begin
                    if (r_active && r_in_pad) begin
                        n_pad = r_pad + 1'b1;
                        if (r_pad == pad_len - 1'b1) begin
                            n_in_pad = 1'b0;
                            n_row    = r_row - 1'b1;
                        end
                    end else if (r_active) begin
                        case (r_k)
                            2'd0: begin
                                n_blue = i_cmd.data;
                                n_k    = 2'd1;
                            end
                            2'd1: begin
                                n_green = i_cmd.data;
                                n_k     = 2'd2;
                            end
                            default: begin
                                n_k         = 2'd0;
                                n_out.red   = i_cmd.data;
                                n_out.green = r_green;
                                n_out.blue  = r_blue;
                                n_out.column = 12'(r_col);
                                n_out.row   = 12'(r_row);
                                n_out.status = ST_PIXEL;
                                n_out.last  = last_col && (r_row == '0);
                                n_out_valid = 1'b1;
                                if (last_col && (r_row == '0)) begin
                                    n_active = 1'b0;
                                end else if (last_col) begin
                                    n_col = '0;
                                    if (pad_len == 2'd0) begin
                                        n_row = r_row - 1'b1;
                                    end else begin
                                        n_in_pad = 1'b1;
                                        n_pad    = 2'd0;
                                    end
                                end else begin
                                    n_col = r_col + 1'b1;
                                end
                            end
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_in_pad    <= 1'b0;
            r_k         <= 2'd0;
            r_pad       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_in_pad    <= n_in_pad;
            r_k         <= n_k;
            r_pad       <= n_pad;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w     <= n_w;
        r_col   <= n_col;
        r_row   <= n_row;
        r_blue  <= n_blue;
        r_green <= n_green;
        r_out   <= n_out;
    end

endmodule

@@ rtl/bmp24_stream_decoder.sv @@
// Top level of the 24-bit BMP stream decoder: front end, command queue and
// back end. Uses bmp24_pkg, bmp24_front, bmp24_queue and bmp24_back.
//
//   Channel   Valid/Ready               Payload     Moves
//   input     i_in_valid / o_in_ready   i_in_data   one file byte per request
//   output    o_out_valid / i_out_ready o_out_data  one pixel or error per request
//
// One byte is accepted per cycle while the command queue has room. The red byte
// of a pixel enters the queue at its accepting edge and is moved into the result
// register when the back end pops it from the queue.
// While a result waits on i_out_ready the back end takes nothing from the queue;
// the queue (Q_DEPTH entries) keeps the input flowing until it fills, and a
// full queue drops o_in_ready.
// Reset is synchronous, active low, and leaves the parser at the start of a file.
module bmp24_stream_decoder #(
    parameter int unsigned MAX_DIM = 4096,
    parameter int unsigned Q_DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  bmp24_pkg::t_in  i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output bmp24_pkg::t_out o_out_data
);
    import bmp24_pkg::*;

    localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
    localparam int unsigned QW    = $bits(t_cmd) + 2 * DIM_W;

    logic             accept;
    logic             push;
    logic             q_full;
    logic             q_valid;
    logic             pop;
    t_cmd             f_cmd;
    logic [DIM_W-1:0] f_w, f_h;
    logic [QW-1:0]    q_in, q_out;
    t_cmd             b_cmd;
    logic [DIM_W-1:0] b_w, b_h;

    assign o_in_ready = !q_full;
    assign accept     = i_in_valid && o_in_ready;

    bmp24_front #(
        .MAX_DIM (MAX_DIM),
        .DIM_W   (DIM_W)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_in     (i_in_data),
        .o_push   (push),
        .o_cmd    (f_cmd),
        .o_cmd_w  (f_w),
        .o_cmd_h  (f_h)
    );

    assign q_in = {f_cmd, f_w, f_h};

    bmp24_queue #(
        .DEPTH (Q_DEPTH),
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push && accept),
        .i_data  (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_data  (q_out)
    );

    assign {b_cmd, b_w, b_h} = q_out;

    bmp24_back #(
        .DIM_W (DIM_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (b_cmd),
        .i_cmd_w     (b_w),
        .i_cmd_h     (b_h),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out_data)
    );

endmodule

@@ tb/bmp24_checker.sv @@
`timescale 1ns / 1ps
// Checker for the BMP stream decoder: decodes every accepted file byte on its own
// and compares each pixel or error request that leaves the block, field by field.
// Depends on bmp24_pkg for the request types, the header layout and the status codes.
module bmp24_checker #(
    parameter int unsigned MAX_DIM = 4096
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_ready,
    input  bmp24_pkg::t_in  i_in_data,
    input  logic            i_out_valid,
    input  logic            i_out_ready,
    input  bmp24_pkg::t_out i_out_data,
    output int              o_fail_count,
    output int              o_pending,
    output int              o_result_count
);
    import bmp24_pkg::*;

    // Decoder state, kept independently of the block.
    logic [31:0] byte_pos;
    logic [31:0] data_ofs;
    logic [31:0] img_w;
    logic [31:0] img_h;
    logic [15:0] bpp;
    logic [14:0] line_cnt;
    logic [11:0] file_row;
    logic [7:0]  held_blue;
    logic [7:0]  held_green;
    t_phase      phase;

    t_out pixel_exp_q[$];
    int   fail_count = 0;
    int   pending = 0;
    int   result_count = 0;

    assign o_fail_count   = fail_count;
    assign o_pending      = pending;
    assign o_result_count = result_count;

    task automatic restart_parse();
        byte_pos   = '0;
        data_ofs   = '0;
        img_w      = '0;
        img_h      = '0;
        bpp        = '0;
        line_cnt   = '0;
        file_row   = '0;
        held_blue  = '0;
        held_green = '0;
        phase      = PH_HEADER;
    endtask

    task automatic decode_byte(input t_in item);
        logic [31:0] pos;
        logic [31:0] idx;
        logic [31:0] line_len;
        logic [31:0] col;
        logic [31:0] top_row;
        logic [1:0]  st;
        logic        fin;
        t_out        res;

        if (item.first_of_file) begin
            restart_parse();
        end
        pos = byte_pos;
        if (byte_pos != '1) begin
            byte_pos = byte_pos + 1;
        end

        if (phase == PH_HEADER) begin
            if (pos >= OFS_DATA_OFS && pos < OFS_DATA_OFS + 4) begin
                data_ofs[8 * (pos - OFS_DATA_OFS) +: 8] = item.file_byte;
            end else if (pos >= OFS_WIDTH && pos < OFS_WIDTH + 4) begin
                img_w[8 * (pos - OFS_WIDTH) +: 8] = item.file_byte;
            end else if (pos >= OFS_HEIGHT && pos < OFS_HEIGHT + 4) begin
                img_h[8 * (pos - OFS_HEIGHT) +: 8] = item.file_byte;
            end else if (pos >= OFS_BPP && pos < OFS_BPP + 2) begin
                bpp[8 * (pos - OFS_BPP) +: 8] = item.file_byte;
            end

            if (pos == HDR_LEN - 1) begin
                // Only the first failing check is reported.
                if (bpp != BPP_SUPPORTED) begin
                    st = ST_BAD_BPP;
                end else if (img_w > MAX_DIM || img_h > MAX_DIM) begin
                    st = ST_TOO_LARGE;
                end else if (data_ofs < HDR_LEN) begin
                    st = ST_BAD_OFFSET;
                end else begin
                    st = ST_PIXEL;
                end

                if (st != ST_PIXEL) begin
                    res        = '0;
                    res.status = st;
                    res.last   = 1'b1;
                    pixel_exp_q.push_back(res);
                    phase = PH_DONE;
                end else if (img_w == 0 || img_h == 0) begin
                    phase = PH_DONE;
                end else begin
                    phase = (data_ofs == HDR_LEN) ? PH_PIXEL : PH_SKIP;
                end
            end
        end else begin
            // The byte at the data offset is already the first pixel byte.
            if (phase == PH_SKIP && pos == data_ofs) begin
                phase = PH_PIXEL;
            end
            if (phase == PH_PIXEL) begin
                idx = 32'(line_cnt);
                fin = 1'b0;
                if (idx < img_w * 3) begin
                    case (idx % 3)
                        0: held_blue = item.file_byte;
                        1: held_green = item.file_byte;
                        default: begin
                            col     = idx / 3;
                            top_row = img_h - 1 - 32'(file_row);
                            fin     = (col == img_w - 1) && (32'(file_row) == img_h - 1);
                            res.red    = item.file_byte;
                            res.green  = held_green;
                            res.blue   = held_blue;
                            res.column = col[11:0];
                            res.row    = top_row[11:0];
                            res.status = ST_PIXEL;
                            res.last   = fin;
                            pixel_exp_q.push_back(res);
                            if (fin) begin
                                phase = PH_DONE;
                            end
                        end
                    endcase
                end
                if (!fin) begin
                    // Padding bytes at the end of a scan line only advance the count.
                    line_len = (img_w * 3 + 3) & ~32'd3;
                    idx = idx + 1;
                    if (idx >= line_len) begin
                        idx = 0;
                        file_row = file_row + 1;
                        if (32'(file_row) >= img_h) begin
                            phase = PH_DONE;
                        end
                    end
                    line_cnt = idx[14:0];
                end
            end
        end
    endtask

    task automatic check_field(input string name, input logic [11:0] want,
                               input logic [11:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            restart_parse();
            pixel_exp_q.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                decode_byte(i_in_data);
            end
            if (i_out_valid && i_out_ready) begin
                result_count++;
                if (pixel_exp_q.size() == 0) begin
                    $error("unexpected request: status %0d, column %0d, row %0d",
                           i_out_data.status, i_out_data.column, i_out_data.row);
                    fail_count++;
                end else begin
                    want = pixel_exp_q.pop_front();
                    check_field("red", 12'(want.red), 12'(i_out_data.red));
                    check_field("green", 12'(want.green), 12'(i_out_data.green));
                    check_field("blue", 12'(want.blue), 12'(i_out_data.blue));
                    check_field("column", want.column, i_out_data.column);
                    check_field("row", want.row, i_out_data.row);
                    check_field("status", 12'(want.status), 12'(i_out_data.status));
                    check_field("last", 12'(want.last), 12'(i_out_data.last));
                end
            end
        end
        pending = pixel_exp_q.size();
    end

endmodule

@@ tb/tb_bmp24_stream_decoder.sv @@
`timescale 1ns / 1ps
// Top of the BMP stream decoder testbench: clock, reset, file byte streams and
// receiver stalls. Depends on bmp24_pkg, bmp24_stream_decoder and bmp24_checker.
module tb_bmp24_stream_decoder;
    import bmp24_pkg::*;

    localparam int unsigned MAX_DIM     = 4096;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          RANDOM_BYTES = 800;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    t_in  in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_data;

    int fail_count;
    int pending;
    int result_count;
    int idle_pct = 0;
    int stall_pct = 0;
    int bytes_sent = 0;
    int files_sent = 0;
    int cycles = 0;

    logic [7:0] file_bytes[$];

    bmp24_stream_decoder #(
        .MAX_DIM(MAX_DIM)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    bmp24_checker #(
        .MAX_DIM(MAX_DIM)
    ) u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_data    (out_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_result_count(result_count)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d requests outstanding", cycles, pending);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic first);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{file_byte: value, first_of_file: first};
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
    endtask

    // Starts a new file image: 54 random header bytes with the decoded fields set.
    task automatic build_header(input logic [31:0] ofs, input logic [31:0] w,
                                input logic [31:0] h, input logic [15:0] bits);
        int k;
        file_bytes.delete();
        repeat (HDR_LEN) file_bytes.push_back(8'($urandom()));
        for (k = 0; k < 4; k++) begin
            file_bytes[OFS_DATA_OFS + k] = ofs[8 * k +: 8];
            file_bytes[OFS_WIDTH + k]    = w[8 * k +: 8];
            file_bytes[OFS_HEIGHT + k]   = h[8 * k +: 8];
        end
        file_bytes[OFS_BPP]     = bits[7:0];
        file_bytes[OFS_BPP + 1] = bits[15:8];
    endtask

    // Gap up to the data offset, then every scan line with its padding.
    task automatic add_body(input int unsigned ofs, input int unsigned w,
                            input int unsigned h);
        int unsigned line_len;
        while (file_bytes.size() < ofs) file_bytes.push_back(8'($urandom()));
        line_len = (w * 3 + 3) & ~32'd3;
        repeat (h * line_len) file_bytes.push_back(8'($urandom()));
    endtask

    task automatic add_tail(input int n);
        repeat (n) file_bytes.push_back(8'($urandom()));
    endtask

    // A negative count sends the whole image; a shorter one leaves it cut off.
    task automatic send_file(input logic first, input int count);
        int n;
        int i;
        n = (count < 0 || count > file_bytes.size()) ? file_bytes.size() : count;
        for (i = 0; i < n; i++) begin
            send_byte(file_bytes[i], first && (i == 0));
        end
        files_sent++;
    endtask

    task automatic random_file();
        int unsigned kind;
        logic [31:0] w;
        logic [31:0] h;
        logic [31:0] ofs;
        logic [31:0] big;
        logic [15:0] bits;
        logic        first;
        logic        broken;
        int          cut;

        kind   = $urandom_range(99);
        w      = $urandom_range(1, 5);
        h      = $urandom_range(1, 3);
        ofs    = ($urandom_range(3) == 0) ? $urandom_range(HDR_LEN + 1, HDR_LEN + 8) : HDR_LEN;
        big    = ($urandom_range(1) == 1) ? MAX_DIM + 1 : ($urandom() | 32'h2000);
        bits   = 16'(BPP_SUPPORTED);
        first  = 1'b1;
        broken = 1'b1;

        if (kind < 8) begin
            bits = ($urandom_range(1) == 1) ? 16'($urandom())
                                            : {8'($urandom_range(1, 255)), 8'(BPP_SUPPORTED)};
            if ($urandom_range(1) == 1) begin
                w = big;
            end
        end else if (kind < 14) begin
            if ($urandom_range(1) == 1) begin
                w = big;
            end else begin
                h = big;
            end
            if ($urandom_range(2) == 0) begin
                ofs = $urandom_range(0, HDR_LEN - 1);
            end
        end else if (kind < 20) begin
            // An offset far past the file leaves the block skipping until the next file.
            ofs = ($urandom_range(3) == 0) ? ($urandom() | 32'h100)
                                           : $urandom_range(0, HDR_LEN - 1);
        end else if (kind < 24) begin
            if ($urandom_range(1) == 1) begin
                w = 0;
            end else begin
                h = 0;
            end
        end else if (kind < 28) begin
            ofs  = $urandom();
            w    = $urandom();
            h    = $urandom();
            bits = 16'($urandom());
        end else begin
            broken = 1'b0;
            // An unmarked file continues whatever parse the previous one left.
            first = ($urandom_range(19) != 0);
        end

        build_header(ofs, w, h, bits);
        if (broken) begin
            add_tail($urandom_range(0, 6));
        end else begin
            add_body(ofs, w, h);
            if ($urandom_range(4) == 0) begin
                add_tail($urandom_range(1, 6));
            end
        end
        cut = ($urandom_range(9) == 0) ? $urandom_range(1, file_bytes.size() - 1) : -1;
        send_file(first, cut);
    endtask

    task automatic run_random(input int idle, input int stall, input int n_bytes);
        int target;
        idle_pct  = idle;
        stall_pct = stall;
        target    = bytes_sent + n_bytes;
        while (bytes_sent < target) random_file();
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Two pixels at the color extremes, with no start marker after reset.
        build_header(HDR_LEN, 2, 1, 16'(BPP_SUPPORTED));
        add_body(HDR_LEN, 2, 1);
        file_bytes[HDR_LEN + 0] = 8'h00;
        file_bytes[HDR_LEN + 1] = 8'h00;
        file_bytes[HDR_LEN + 2] = 8'h00;
        file_bytes[HDR_LEN + 3] = 8'hFF;
        file_bytes[HDR_LEN + 4] = 8'hFF;
        file_bytes[HDR_LEN + 5] = 8'hFF;
        send_file(1'b0, -1);

        // Header errors, including combinations where the earlier check must win.
        build_header(HDR_LEN, 1, 1, 16'd8);
        add_tail(3);
        send_file(1'b1, -1);
        build_header(HDR_LEN, MAX_DIM + 1, 1, 16'(BPP_SUPPORTED));
        send_file(1'b1, -1);
        build_header(HDR_LEN, 1, 32'hFFFF_FFFF, 16'(BPP_SUPPORTED));
        send_file(1'b1, -1);
        build_header(HDR_LEN - 1, 1, 1, 16'(BPP_SUPPORTED));
        send_file(1'b1, -1);
        build_header(0, 32'hFFFF_FFFF, 1, 16'd32);
        send_file(1'b1, -1);
        build_header(0, 2, 32'h0001_0000, 16'(BPP_SUPPORTED));
        send_file(1'b1, -1);

        // Empty image: no request at all, trailing bytes ignored.
        build_header(HDR_LEN, 0, 3, 16'(BPP_SUPPORTED));
        add_tail(4);
        send_file(1'b1, -1);

        // Skipped gap before the pixel data and bytes after the last pixel.
        build_header(HDR_LEN + 6, 3, 2, 16'(BPP_SUPPORTED));
        add_body(HDR_LEN + 6, 3, 2);
        add_tail(5);
        send_file(1'b1, -1);

        // Largest legal size, abandoned after ten pixels of the first scan line (row MAX_DIM - 1).
        build_header(HDR_LEN, MAX_DIM, MAX_DIM, 16'(BPP_SUPPORTED));
        add_tail(30);
        send_file(1'b1, -1);

        // Restart in the middle of the pixel data, then a complete file.
        build_header(HDR_LEN, 2, 2, 16'(BPP_SUPPORTED));
        add_body(HDR_LEN, 2, 2);
        send_file(1'b1, HDR_LEN + 7);
        build_header(HDR_LEN, 1, 2, 16'(BPP_SUPPORTED));
        add_body(HDR_LEN, 1, 2);
        send_file(1'b1, -1);

        run_random(0, 0, RANDOM_BYTES / 4);
        run_random(62, 0, RANDOM_BYTES / 4);
        run_random(0, 62, RANDOM_BYTES / 4);
        run_random(33, 33, RANDOM_BYTES / 4);

        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (20) @(posedge clk);

        $display("Streamed %0d file bytes in %0d files under four idle and stall mixes.",
                 bytes_sent, files_sent);
        $display("Checked %0d pixel and error requests against the decoded files.",
                 result_count);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
